FILE: hdl/lzgc_pkg.sv
// ----------------------------------------------------------------------------
// lzgc_pkg
// shared types and constants of the greedy lz77 compressor core
// ----------------------------------------------------------------------------
package lzgc_pkg;

   // defaults of the top level parameters
   localparam int WindowDepthDefault = 32768;
   localparam int MatchLimitDefault  = 255;

   // ring buffer geometry, fixed by the token format
   localparam int RingAddrWidth = 16;

   // field widths
   localparam int ByteWidth  = 8;
   localparam int LenWidth   = 8;
   localparam int DistWidth  = 16;
   localparam int CsrWidth   = 16;

   // register reset values
   localparam logic [LenWidth-1:0]  MatchFloorReset  = 8'd3;
   localparam logic [DistWidth-1:0] MaxDistanceReset = 16'd32768;

   // token header bytes
   localparam logic [ByteWidth-1:0] HdrMatch   = 8'h01;
   localparam logic [ByteWidth-1:0] HdrLiteral = 8'h00;

   // request kinds
   localparam logic ReqData  = 1'b0;
   localparam logic ReqDrain = 1'b1;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_MATCH_FLOOR  = 1'b0,
      CSR_MAX_DISTANCE = 1'b1
   } csr_index_type;

   // which token byte the output register takes
   typedef enum logic [2:0] {
      EMIT_HDR,
      EMIT_OFF_LO,
      EMIT_OFF_HI,
      EMIT_LEN,
      EMIT_LIT
   } emit_sel_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_NEXT,
      ST_ISSUE,
      ST_CHECK,
      ST_CAND,
      ST_EMIT0,
      ST_EMIT1,
      ST_EMIT2,
      ST_EMIT3,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic         ring_wr;
      logic         arm;
      logic         hist_clr;
      logic         init;
      logic         k_clr;
      logic         k_inc;
      logic         cand_end;
      logic         rsp_load;
      emit_sel_type emit_sel;
      logic         commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                la_empty;
      logic                la_full;
      logic                la_full_next;
      logic                k_eq_avail;
      logic                bytes_eq;
      logic                loop_go;
      logic                is_match;
      logic                rsp_free;
      logic [LenWidth-1:0] la_count;
   } sts_type;

endpackage

FILE: hdl/lzgc_req_if.sv
// ----------------------------------------------------------------------------
// lzgc_req_if
// request channel: data bytes and drain requests
// ----------------------------------------------------------------------------
interface lzgc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [lzgc_pkg::ByteWidth-1:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

FILE: hdl/lzgc_rsp_if.sv
// ----------------------------------------------------------------------------
// lzgc_rsp_if
// response channel: one token byte per transaction
// ----------------------------------------------------------------------------
interface lzgc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lzgc_pkg::ByteWidth-1:0] out_byte;
   logic                          token_end;
   logic                          stream_end;

   modport source (output valid, output out_byte, output token_end, output stream_end,
                   input ready);
   modport sink   (input valid, input out_byte, input token_end, input stream_end,
                   output ready);
endinterface

FILE: hdl/lzgc_ctrl.sv
// ----------------------------------------------------------------------------
// lzgc_ctrl
// controller: accepts requests, sequences the window search and token output
// ----------------------------------------------------------------------------
module lzgc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   input  lzgc_pkg::sts_type   sts,
   output lzgc_pkg::cmd_type   cmd
);

   lzgc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzgc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzgc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == lzgc_pkg::ReqData) begin
                  if (!sts.la_full && sts.la_full_next) begin
                     state_in = lzgc_pkg::ST_INIT;
                  end
               end else if (!sts.la_empty) begin
                  state_in = lzgc_pkg::ST_INIT;
               end
            end
         end
         lzgc_pkg::ST_INIT:  state_in = lzgc_pkg::ST_NEXT;
         lzgc_pkg::ST_NEXT: begin
            state_in = sts.loop_go ? lzgc_pkg::ST_ISSUE : lzgc_pkg::ST_EMIT0;
         end
         lzgc_pkg::ST_ISSUE: begin
            state_in = sts.k_eq_avail ? lzgc_pkg::ST_CAND : lzgc_pkg::ST_CHECK;
         end
         lzgc_pkg::ST_CHECK: begin
            state_in = sts.bytes_eq ? lzgc_pkg::ST_ISSUE : lzgc_pkg::ST_CAND;
         end
         lzgc_pkg::ST_CAND:  state_in = lzgc_pkg::ST_NEXT;
         lzgc_pkg::ST_EMIT0: begin
            if (sts.rsp_free) begin
               state_in = lzgc_pkg::ST_EMIT1;
            end
         end
         lzgc_pkg::ST_EMIT1: begin
            if (sts.rsp_free) begin
               state_in = sts.is_match ? lzgc_pkg::ST_EMIT2 : lzgc_pkg::ST_COMMIT;
            end
         end
         lzgc_pkg::ST_EMIT2: begin
            if (sts.rsp_free) begin
               state_in = lzgc_pkg::ST_EMIT3;
            end
         end
         lzgc_pkg::ST_EMIT3: begin
            if (sts.rsp_free) begin
               state_in = lzgc_pkg::ST_COMMIT;
            end
         end
         lzgc_pkg::ST_COMMIT: state_in = lzgc_pkg::ST_IDLE;
         default:             state_in = lzgc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.emit_sel = lzgc_pkg::EMIT_HDR;
      unique case (state_ff)
         lzgc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.arm = 1'b1;
               if (req_type == lzgc_pkg::ReqData) begin
                  cmd.ring_wr = !sts.la_full;
               end else begin
                  cmd.hist_clr = sts.la_empty;
               end
            end
         end
         lzgc_pkg::ST_INIT:  cmd.init     = 1'b1;
         lzgc_pkg::ST_NEXT:  cmd.k_clr    = 1'b1;
         lzgc_pkg::ST_ISSUE: cmd.k_clr    = 1'b0;
         lzgc_pkg::ST_CHECK: cmd.k_inc    = sts.bytes_eq;
         lzgc_pkg::ST_CAND:  cmd.cand_end = 1'b1;
         lzgc_pkg::ST_EMIT0: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.emit_sel = lzgc_pkg::EMIT_HDR;
         end
         lzgc_pkg::ST_EMIT1: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.emit_sel = sts.is_match ? lzgc_pkg::EMIT_OFF_LO : lzgc_pkg::EMIT_LIT;
         end
         lzgc_pkg::ST_EMIT2: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.emit_sel = lzgc_pkg::EMIT_OFF_HI;
         end
         lzgc_pkg::ST_EMIT3: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.emit_sel = lzgc_pkg::EMIT_LEN;
         end
         lzgc_pkg::ST_COMMIT: cmd.commit = 1'b1;
         default:             cmd.commit = 1'b0;
      endcase
   end

endmodule

FILE: hdl/lzgc_dpath.sv
// ----------------------------------------------------------------------------
// lzgc_dpath
// datapath: byte ring, lookahead and history counters, match search
// registers, configuration registers and the output register
// ----------------------------------------------------------------------------
module lzgc_dpath #(
   parameter int WINDOW_DEPTH = lzgc_pkg::WindowDepthDefault,
   parameter int MATCH_LIMIT  = lzgc_pkg::MatchLimitDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  lzgc_pkg::csr_index_type              csr_index,
   input  logic [lzgc_pkg::CsrWidth-1:0]        csr_wdata,
   input  logic                                 req_type,
   input  logic [lzgc_pkg::ByteWidth-1:0]       data_byte,
   input  logic                                 rsp_ready,
   input  lzgc_pkg::cmd_type                    cmd,
   output lzgc_pkg::sts_type                    sts,
   output logic                                 rsp_valid,
   output logic [lzgc_pkg::ByteWidth-1:0]       out_byte,
   output logic                                 token_end,
   output logic                                 stream_end
);

   localparam int AW = lzgc_pkg::RingAddrWidth;
   localparam int LW = lzgc_pkg::LenWidth;
   localparam int DW = lzgc_pkg::DistWidth;
   localparam int BW = lzgc_pkg::ByteWidth;
   localparam int RingDepth = 1 << AW;
   localparam int HistCap = (WINDOW_DEPTH < RingDepth - MATCH_LIMIT) ?
                            WINDOW_DEPTH : RingDepth - MATCH_LIMIT;
   localparam logic [DW:0]  HistCapVal = (DW+1)'(HistCap);
   localparam logic [LW:0]  LimitVal   = (LW+1)'(MATCH_LIMIT);

   // configuration registers
   logic [LW-1:0] match_floor_ff, match_floor_in;
   logic [DW-1:0] max_dist_ff,  max_dist_in;

   // stream state
   logic [AW-1:0] head_ff, head_in;
   logic [LW-1:0] la_count_ff, la_count_in;
   logic [DW-1:0] hist_ff, hist_in;
   logic          last_ff, last_in;

   // search state
   logic [DW-1:0] d_ff, d_in;
   logic [LW-1:0] k_ff, k_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic [DW-1:0] best_off_ff, best_off_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] out_byte_ff, out_byte_in;
   logic          token_end_ff, token_end_in;
   logic          stream_end_ff, stream_end_in;

   // ring memory
   logic [BW-1:0] ring_mem [RingDepth];
   logic [BW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0] addr_a, addr_b, addr_w;

   logic [LW-1:0] min_eff;
   logic [DW-1:0] reach;
   logic          is_match;
   logic [LW-1:0] adv;
   logic          fin;
   logic [DW:0]   hist_sum;
   logic          rsp_free;

   // ring addresses: candidate, head and write tail
   assign addr_a = head_ff - AW'(d_ff) + AW'(k_ff);
   assign addr_b = head_ff + AW'(k_ff);
   assign addr_w = head_ff + AW'(la_count_ff);

   // ring memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd.ring_wr) begin
         ring_mem[addr_w] <= data_byte;
      end
      rd_a_ff <= ring_mem[addr_a];
      rd_b_ff <= ring_mem[addr_b];
   end

   // token decision terms
   assign min_eff  = (match_floor_ff == '0) ? LW'(1) : match_floor_ff;
   assign reach    = (max_dist_ff < hist_ff) ? max_dist_ff : hist_ff;
   assign is_match = best_len_ff >= min_eff;
   assign adv      = is_match ? best_len_ff : LW'(1);
   assign fin      = last_ff && (la_count_ff == adv);
   assign hist_sum = {1'b0, hist_ff} + (DW+1)'(adv);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // status to the controller
   always_comb begin
      sts.la_empty     = la_count_ff == '0;
      sts.la_full      = {1'b0, la_count_ff} >= LimitVal;
      sts.la_full_next = ({1'b0, la_count_ff} + (LW+1)'(1)) >= LimitVal;
      sts.k_eq_avail   = k_ff == la_count_ff;
      sts.bytes_eq     = rd_a_ff == rd_b_ff;
      sts.loop_go      = (d_ff != '0) && (best_len_ff < la_count_ff);
      sts.is_match     = is_match;
      sts.rsp_free     = rsp_free;
      sts.la_count     = la_count_ff;
   end

   // configuration and stream state next values
   always_comb begin
      match_floor_in = match_floor_ff;
      max_dist_in    = max_dist_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lzgc_pkg::CSR_MATCH_FLOOR:  match_floor_in = csr_wdata[LW-1:0];
            lzgc_pkg::CSR_MAX_DISTANCE: max_dist_in    = csr_wdata[DW-1:0];
            default:                    max_dist_in    = max_dist_ff;
         endcase
      end

      head_in     = head_ff;
      la_count_in = la_count_ff;
      hist_in     = hist_ff;
      last_in     = cmd.arm ? req_type : last_ff;
      if (cmd.ring_wr) begin
         la_count_in = la_count_ff + LW'(1);
      end
      if (cmd.hist_clr) begin
         hist_in = '0;
      end
      if (cmd.commit) begin
         head_in     = head_ff + AW'(adv);
         la_count_in = la_count_ff - adv;
         if (fin) begin
            hist_in = '0;
         end else if (hist_sum > HistCapVal) begin
            hist_in = HistCapVal[DW-1:0];
         end else begin
            hist_in = hist_sum[DW-1:0];
         end
      end
   end

   // search next values
   always_comb begin
      d_in        = d_ff;
      k_in        = k_ff;
      best_len_in = best_len_ff;
      best_off_in = best_off_ff;
      if (cmd.init) begin
         d_in        = reach;
         k_in        = '0;
         best_len_in = '0;
         best_off_in = '0;
      end
      if (cmd.k_clr) begin
         k_in = '0;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + LW'(1);
      end
      if (cmd.cand_end) begin
         d_in = d_ff - DW'(1);
         if (k_ff > best_len_ff) begin
            best_len_in = k_ff;
            best_off_in = d_ff;
         end
      end
   end

   // output register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      token_end_in  = token_end_ff;
      stream_end_in = stream_end_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         token_end_in  = 1'b0;
         stream_end_in = 1'b0;
         unique case (cmd.emit_sel)
            lzgc_pkg::EMIT_HDR: begin
               out_byte_in = is_match ? lzgc_pkg::HdrMatch : lzgc_pkg::HdrLiteral;
            end
            lzgc_pkg::EMIT_OFF_LO: out_byte_in = best_off_ff[BW-1:0];
            lzgc_pkg::EMIT_OFF_HI: out_byte_in = best_off_ff[DW-1:BW];
            lzgc_pkg::EMIT_LEN: begin
               out_byte_in   = best_len_ff;
               token_end_in  = 1'b1;
               stream_end_in = fin;
            end
            lzgc_pkg::EMIT_LIT: begin
               out_byte_in   = rd_b_ff;
               token_end_in  = 1'b1;
               stream_end_in = fin;
            end
            default: out_byte_in = out_byte_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         match_floor_ff <= lzgc_pkg::MatchFloorReset;
         max_dist_ff    <= lzgc_pkg::MaxDistanceReset;
         head_ff        <= '0;
         la_count_ff    <= '0;
         hist_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         match_floor_ff <= match_floor_in;
         max_dist_ff    <= max_dist_in;
         head_ff        <= head_in;
         la_count_ff    <= la_count_in;
         hist_ff        <= hist_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      d_ff          <= d_in;
      k_ff          <= k_in;
      best_len_ff   <= best_len_in;
      best_off_ff   <= best_off_in;
      out_byte_ff   <= out_byte_in;
      token_end_ff  <= token_end_in;
      stream_end_ff <= stream_end_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign out_byte   = out_byte_ff;
   assign token_end  = token_end_ff;
   assign stream_end = stream_end_ff;

endmodule

FILE: hdl/lz77_greedy_compressor_core.sv
// A data byte is written to the ring; a token decision searches candidate distances
// running up to min(max_distance, history), comparing bytes through the two ring read
// ports, then emits a 2-byte literal or 4-byte match token. Reset is synchronous:
// counters clear, the match length floor returns to 3 and max_distance to 32768;
// the ring needs no clearing pass.
// ----------------------------------------------------------------------------
// lz77_greedy_compressor_core
// greedy lz77 compressor with exhaustive window search, top level
// ----------------------------------------------------------------------------
module lz77_greedy_compressor_core #(
   parameter int WINDOW_DEPTH = lzgc_pkg::WindowDepthDefault,
   parameter int MATCH_LIMIT  = lzgc_pkg::MatchLimitDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   lzgc_req_if.sink                        req_chan,
   lzgc_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  lzgc_pkg::csr_index_type         csr_index,
   input  logic [lzgc_pkg::CsrWidth-1:0]   csr_wdata
);

   lzgc_pkg::cmd_type cmd;
   lzgc_pkg::sts_type sts;

   // controller
   lzgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   lzgc_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MATCH_LIMIT  (MATCH_LIMIT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_type   (req_chan.req_type),
      .data_byte  (req_chan.data_byte),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_chan.valid),
      .out_byte   (rsp_chan.out_byte),
      .token_end  (rsp_chan.token_end),
      .stream_end (rsp_chan.stream_end)
   );

   // output register is only loaded when it is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("output register loaded while occupied");

   // a push never lands in a full lookahead
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ring_wr |-> !sts.la_full)
      else $error("push into full lookahead");

   // a committed token always leaves room in the lookahead
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (sts.la_count < 8'(MATCH_LIMIT)))
      else $error("lookahead still full after commit");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the greedy lz77 compressor core: short byte
// streams with drains run under several match length floor / max_distance
// settings, and every token byte is checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HistCap    = 32768;
   localparam int LookSize   = 255;
   localparam int CycleLimit = 6000000;

   typedef struct {
      logic                           is_drain;
      logic [lzgc_pkg::ByteWidth-1:0] data;
   } req_item_type;

   typedef struct {
      logic [lzgc_pkg::ByteWidth-1:0] out_byte;
      logic                           token_end;
      logic                           stream_end;
   } token_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   lzgc_pkg::csr_index_type       csr_index = lzgc_pkg::CSR_MATCH_FLOOR;
   logic [lzgc_pkg::CsrWidth-1:0] csr_wdata = '0;

   lzgc_req_if req_bus ();
   lzgc_rsp_if rsp_bus ();

   lz77_greedy_compressor_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [7:0]  ring [0:65535];
   logic [15:0] head_ptr = '0;
   int          look_cnt = 0;
   int          hist_cnt = 0;
   int          match_floor_q = 3;
   int          max_dist_q = 32768;

   req_item_type   pending_reqs[$];
   token_byte_type expected_bytes[$];
   int          err_cnt = 0;
   int          cycles = 0;
   int          match_tokens = 0;
   int          literal_tokens = 0;
   int          stream_ends = 0;
   bit          no_idle = 1'b0;

   // decide one token at the lookahead head, queue its bytes
   function automatic void decide_token(bit drain);
      int          reach, minm, best_len, best_off, k, adv, d;
      logic [15:0] start;
      bit          fin;
      best_len = 0;
      best_off = 0;
      reach = (max_dist_q < hist_cnt) ? max_dist_q : hist_cnt;
      minm = (match_floor_q == 0) ? 1 : match_floor_q;
      for (d = reach; d >= 1 && best_len < look_cnt; d--) begin
         start = head_ptr - 16'(d);
         k = 0;
         while (k < look_cnt && ring[16'(start + 16'(k))] == ring[16'(head_ptr + 16'(k))])
            k++;
         if (k > best_len) begin
            best_len = k;
            best_off = d;
         end
      end
      adv = (best_len >= minm) ? best_len : 1;
      fin = drain && (look_cnt == adv);
      if (best_len >= minm) begin
         expected_bytes.push_back('{lzgc_pkg::HdrMatch, 1'b0, 1'b0});
         expected_bytes.push_back('{8'(best_off), 1'b0, 1'b0});
         expected_bytes.push_back('{8'(best_off >> 8), 1'b0, 1'b0});
         expected_bytes.push_back('{8'(best_len), 1'b1, fin});
         match_tokens++;
      end else begin
         expected_bytes.push_back('{lzgc_pkg::HdrLiteral, 1'b0, 1'b0});
         expected_bytes.push_back('{ring[head_ptr], 1'b1, fin});
         literal_tokens++;
      end
      if (fin) stream_ends++;
      head_ptr = head_ptr + 16'(adv);
      look_cnt -= adv;
      hist_cnt += adv;
      if (hist_cnt > HistCap) hist_cnt = HistCap;
      if (fin) hist_cnt = 0;
   endfunction

   // apply one accepted transaction to the predictor
   function automatic void predict_tokens(req_item_type it);
      if (it.is_drain == lzgc_pkg::ReqData) begin
         if (look_cnt >= LookSize) return;
         ring[16'(head_ptr + 16'(look_cnt))] = it.data;
         look_cnt++;
         if (look_cnt >= LookSize) decide_token(1'b0);
      end else if (look_cnt == 0) begin
         hist_cnt = 0;
      end else begin
         decide_token(1'b1);
      end
   endfunction

   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
   endfunction

   // request driver
   req_item_type cur_req;
   int           req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.req_type  <= lzgc_pkg::ReqData;
         req_bus.data_byte <= '0;
         req_gap           <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_tokens(cur_req);
         if (req_bus.valid && !req_bus.ready) begin
            // hold the current transaction
         end else if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap       <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.req_type  <= cur_req.is_drain;
            req_bus.data_byte <= cur_req.data;
            req_gap           <= draw_wait();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor with random stalls
   int rsp_stall = 0;
   always @(posedge clock) begin
      token_byte_type exp_b;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected token byte %h te=%b se=%b", $time,
                        rsp_bus.out_byte, rsp_bus.token_end, rsp_bus.stream_end);
               err_cnt++;
            end else begin
               exp_b = expected_bytes.pop_front();
               if (rsp_bus.out_byte !== exp_b.out_byte ||
                   rsp_bus.token_end !== exp_b.token_end ||
                   rsp_bus.stream_end !== exp_b.stream_end) begin
                  $display("%0t: mismatch expected %h te=%b se=%b, got %h te=%b se=%b",
                           $time, exp_b.out_byte, exp_b.token_end, exp_b.stream_end,
                           rsp_bus.out_byte, rsp_bus.token_end, rsp_bus.stream_end);
                  err_cnt++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall     <= rsp_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready) rsp_stall <= draw_wait();
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b);
      pending_reqs.push_back('{lzgc_pkg::ReqData, b});
   endtask

   // one stream: bytes then one drain more than bytes, enough to empty it with at least one on empty
   task automatic push_stream(int n, int alpha);
      int i;
      for (i = 0; i < n; i++) begin
         if (alpha > 0 && $urandom_range(0, 9) < 8)
            push_byte(8'(8'h41 + $urandom_range(0, alpha - 1)));
         else
            push_byte(8'($urandom));
      end
      for (i = 0; i <= n; i++) pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'($urandom)});
   endtask

   // wait for the block to go idle, then write both registers
   task automatic settle_and_config(int mm, int md);
      wait (pending_reqs.size() == 0 && !req_bus.valid);
      wait (expected_bytes.size() == 0);
      repeat (100) @(posedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= lzgc_pkg::CSR_MATCH_FLOOR;
      csr_wdata <= 16'(mm);
      @(posedge clock);
      csr_index <= lzgc_pkg::CSR_MAX_DISTANCE;
      csr_wdata <= 16'(md);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      match_floor_q = mm & 8'hFF;
      max_dist_q    = md & 16'hFFFF;
   endtask

   initial begin
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, byte extremes, empty drain, single byte
      no_idle = 1'b1;
      for (i = 0; i < 6; i++) push_byte((i % 2) ? 8'hFF : 8'h00);
      for (i = 0; i < 7; i++) pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'h00});
      push_byte(8'h5A);
      pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'hFF});
      pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'h00});

      // shortest match length, nearest distance: overlapped run
      settle_and_config(1, 1);
      no_idle = 1'b0;
      for (i = 0; i < 5; i++) push_byte(8'h61);
      push_byte(8'h62);
      for (i = 0; i < 7; i++) pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'h00});
      for (i = 0; i < 2; i++) push_stream($urandom_range(1, 6), 3);

      // highest match floor: repeated pattern stays literal
      settle_and_config(255, 32768);
      for (i = 0; i < 9; i++) push_byte(8'(8'h30 + (i % 3)));
      for (i = 0; i < 10; i++) pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'h00});

      // zero registers: every token a literal
      settle_and_config(0, 0);
      for (i = 0; i < 2; i++) push_stream($urandom_range(1, 5), 2);

      // short window
      settle_and_config(2, 16);
      push_stream(8, 4);

      // defaults again with random streams, some preceded by an extra drain on an empty lookahead
      settle_and_config(3, 32768);
      for (i = 0; i < 2; i++) begin
         if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back('{lzgc_pkg::ReqDrain, 8'($urandom)});
         push_stream($urandom_range(1, 6), $urandom_range(0, 4));
      end

      // widest distance code and a mid match length
      settle_and_config(4, 65535);
      push_stream($urandom_range(1, 8), $urandom_range(1, 4));

      wait (pending_reqs.size() == 0 && !req_bus.valid);
      wait (expected_bytes.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d match and %0d literal tokens, %0d flagged stream ends",
               match_tokens, literal_tokens, stream_ends);
      $display("over seven register settings including zero and full-range values");
      if (err_cnt == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

FILE: files.f
hdl/lzgc_pkg.sv
hdl/lzgc_req_if.sv
hdl/lzgc_rsp_if.sv
hdl/lzgc_ctrl.sv
hdl/lzgc_dpath.sv
hdl/lz77_greedy_compressor_core.sv
verif/tb_top.sv
